/* design/fbpc_pkg.sv */
// Shared types, codes and arithmetic helpers of the framebuffer pixel compositor.
`default_nettype none
package fbpc_pkg;

  // Pixel request kinds carried in the input tuser.
  localparam logic [1:0] KIND_GLYPH = 2'd0;
  localparam logic [1:0] KIND_LOGO  = 2'd1;
  localparam logic [1:0] KIND_FILL  = 2'd2;

  // Pixel format code that puts red in the low byte; every other code puts it in byte two.
  localparam logic [1:0] FMT_RED_LOW = 2'd0;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd0;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [2:0] REG_ROW_STRIDE    = 3'd3;
  localparam logic [2:0] REG_OFFSET_X      = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y      = 3'd5;

  localparam logic [7:0] MAX_LEVEL = 8'd192;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  pixel_format;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [13:0] row_stride;
    logic [5:0]  offset_x;
    logic [5:0]  offset_y;
  } cfg_t;

  // One classified request, as it waits between front and back.
  typedef struct packed {
    logic [1:0]  kind;
    logic        pre_we;      // in bounds and not skipped by kind
    logic [12:0] x_sum;
    logic [24:0] row_base;    // (y + offset_y) * row_stride, low bits
    logic [7:0]  src_r;
    logic [7:0]  src_g;
    logic [7:0]  src_b;
    logic [15:0] prod_r;      // destination channel times (255 - alpha)
    logic [15:0] prod_g;
    logic [15:0] prod_b;
    logic [15:0] glyph_prod;  // coverage times the maximum level
  } entry_t;

  // Exact floor(v / 255) for every 16-bit v below 65280.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + {9'b0, v[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [31:0] pack_rgb(input logic [1:0] fmt, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b);
    return (fmt == FMT_RED_LOW) ? {8'h00, b, g, r} : {8'h00, r, g, b};
  endfunction

endpackage
`default_nettype wire

/* design/fbpc_front.sv */
// Front end: offsets and bounds-checks coordinates, classifies the request, forms products.
`default_nettype none
module fbpc_front
  import fbpc_pkg::*;
(
  input  wire cfg_t        cfg,
  input  wire logic [1:0]  kind,
  input  wire logic [87:0] data,
  output entry_t           entry
);

  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [7:0]  src_a;
  logic [31:0] under;
  logic [7:0]  inv;
  logic [7:0]  dst_r;
  logic [7:0]  dst_b;
  logic [12:0] x_sum;
  logic [12:0] y_sum;
  logic [26:0] base_full;
  logic        in_bounds;

  assign pos_x = data[11:0];
  assign pos_y = data[23:12];
  assign src_a = data[55:48];
  assign under = data[87:56];

  assign inv   = 8'hFF - src_a;
  assign dst_r = (cfg.pixel_format == FMT_RED_LOW) ? under[7:0] : under[23:16];
  assign dst_b = (cfg.pixel_format == FMT_RED_LOW) ? under[23:16] : under[7:0];

  assign x_sum     = {1'b0, pos_x} + {7'b0, cfg.offset_x};
  assign y_sum     = {1'b0, pos_y} + {7'b0, cfg.offset_y};
  assign base_full = 27'(y_sum) * 27'(cfg.row_stride);
  assign in_bounds = (x_sum < cfg.screen_width) && (y_sum < cfg.screen_height);

  always_comb begin
    entry.kind       = kind;
    entry.x_sum      = x_sum;
    entry.row_base   = base_full[24:0];
    entry.src_r      = data[31:24];
    entry.src_g      = data[39:32];
    entry.src_b      = data[47:40];
    entry.prod_r     = 16'(dst_r) * 16'(inv);
    entry.prod_g     = 16'(under[15:8]) * 16'(inv);
    entry.prod_b     = 16'(dst_b) * 16'(inv);
    entry.glyph_prod = 16'(data[31:24]) * 16'(MAX_LEVEL);
    unique case (kind)
      KIND_GLYPH: entry.pre_we = in_bounds;
      KIND_LOGO:  entry.pre_we = in_bounds && (src_a != 8'h00);
      KIND_FILL:  entry.pre_we = in_bounds;
      default:    entry.pre_we = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

/* design/fbpc_queue.sv */
// Short FIFO of classified requests between the front end and the back end.
`default_nettype none
module fbpc_queue
  import fbpc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head_entry
);

  entry_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

/* design/fbpc_back.sv */
// Back end: scaling, source-over blend with saturation, packing, address and output register.
`default_nettype none
module fbpc_back
  import fbpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  pixel_format,
  input  wire logic        head_valid,
  input  wire entry_t      head_entry,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,
  output logic             out_tuser
);

  logic        valid_r;
  logic        we_r, we_nxt;
  logic [63:0] data_r, data_nxt;
  logic        take;
  logic [7:0]  level;
  logic [7:0]  blend_r, blend_g, blend_b;
  logic [31:0] value;
  logic [24:0] addr;

  function automatic logic [7:0] sat_add(input logic [7:0] src, input logic [15:0] prod);
    logic [8:0] s;
    s = {1'b0, src} + {1'b0, div255(prod)};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  assign take = !valid_r || out_tready;
  assign pop  = head_valid && take;

  assign level   = div255(head_entry.glyph_prod);
  assign blend_r = sat_add(head_entry.src_r, head_entry.prod_r);
  assign blend_g = sat_add(head_entry.src_g, head_entry.prod_g);
  assign blend_b = sat_add(head_entry.src_b, head_entry.prod_b);
  assign addr    = head_entry.row_base + {12'b0, head_entry.x_sum};

  always_comb begin
    we_nxt = head_entry.pre_we;
    value  = '0;
    unique case (head_entry.kind)
      KIND_GLYPH: begin
        we_nxt = head_entry.pre_we && (level != 8'h00);
        value  = pack_rgb(pixel_format, level, level, level);
      end
      KIND_LOGO: begin
        value = pack_rgb(pixel_format, blend_r, blend_g, blend_b);
      end
      KIND_FILL: begin
        value = pack_rgb(pixel_format, head_entry.src_r, head_entry.src_g, head_entry.src_b);
      end
      default: begin
        we_nxt = 1'b0;
      end
    endcase
    data_nxt = we_nxt ? {7'b0, value, addr} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      we_r   <= we_nxt;
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = we_r;
  assign out_tdata  = data_r;

endmodule
`default_nettype wire

/* design/framebuffer_pixel_compositor.sv */
// Top level of the framebuffer pixel compositor: register file, front end, queue, back end.
//
//   Channel  Direction  Contents
//   in_      slave      one pixel request per word (kind in tuser, coordinates and colors)
//   out_     master     one write result per word (write flag in tuser, address and pixel)
//   APB      slave      six configuration registers at byte addresses 0x00 to 0x14
//
// The block takes one word per clock while the queue has room and returns one word per
// clock while the output is not stalled. The front end forms all products in the cycle
// of acceptance and writes them into a four-entry queue; the back end finishes the
// arithmetic on the queue head and loads the output register from it.
// Reset (synchronous, active low) empties the queue and the output register and loads
// the register defaults. A stalled output only stops the input once the queue is full.
`default_nettype none
module framebuffer_pixel_compositor
  import fbpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input words.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata from bit 0: pos_x[11:0], pos_y[23:12], src_red[31:24], src_green[39:32],
  // src_blue[47:40], src_alpha[55:48], under_pixel[87:56]
  input  wire logic [87:0] in_tdata,
  // tuser: kind[1:0]
  input  wire logic [1:0]  in_tuser,
  // Result words.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata from bit 0: write_address[24:0], pixel_value[56:25], zero fill[63:57]
  output logic [63:0]      out_tdata,
  // tuser: write_enable[0]
  output logic             out_tuser,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg_r;
  logic       cfg_write;
  logic [2:0] reg_idx;
  entry_t     front_entry;
  entry_t     head_entry;
  logic       q_full;
  logic       q_pop;
  logic       head_valid;
  logic       push;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Registers are written at the access cycle; an address past the list writes nothing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format  <= 2'd1;
      cfg_r.screen_width  <= 13'd1024;
      cfg_r.screen_height <= 13'd768;
      cfg_r.row_stride    <= 14'd1024;
      cfg_r.offset_x      <= 6'd0;
      cfg_r.offset_y      <= 6'd0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_PIXEL_FORMAT:  cfg_r.pixel_format  <= pwdata[1:0];
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= pwdata[12:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= pwdata[12:0];
        REG_ROW_STRIDE:    cfg_r.row_stride    <= pwdata[13:0];
        REG_OFFSET_X:      cfg_r.offset_x      <= pwdata[5:0];
        REG_OFFSET_Y:      cfg_r.offset_y      <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PIXEL_FORMAT:  prdata = {30'b0, cfg_r.pixel_format};
      REG_SCREEN_WIDTH:  prdata = {19'b0, cfg_r.screen_width};
      REG_SCREEN_HEIGHT: prdata = {19'b0, cfg_r.screen_height};
      REG_ROW_STRIDE:    prdata = {18'b0, cfg_r.row_stride};
      REG_OFFSET_X:      prdata = {26'b0, cfg_r.offset_x};
      REG_OFFSET_Y:      prdata = {26'b0, cfg_r.offset_y};
      default:           prdata = '0;
    endcase
  end

  // The input is held off only while the queue is full.
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  fbpc_front u_front (
    .cfg   (cfg_r),
    .kind  (in_tuser),
    .data  (in_tdata),
    .entry (front_entry)
  );

  fbpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  fbpc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_format (cfg_r.pixel_format),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench of the pixel compositor: directed table and random pixel traffic.
`timescale 1ns / 1ps
module tb
  import fbpc_pkg::*;
();

  // The one kind code that the package leaves unnamed; the block must drop it.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Cycles allowed after the last result before the configuration is touched
  // or the run ends.
  localparam int SETTLE_CYCLES = 6;

  // Random words per configuration phase, and the number of phases.
  localparam int PHASE_WORDS = 205;
  localparam int PHASE_COUNT = 8;

  // One pixel request, as it is packed onto the input channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [31:0] under;
  } pixel_req_t;

  // One framebuffer write, as it leaves on the result channel.
  typedef struct packed {
    logic        we;
    logic [24:0] addr;
    logic [31:0] pix;
  } wr_result_t;

  // A row of the directed table. When typed is set, res holds the write that
  // can be read off directly; otherwise the predictor supplies it.
  typedef struct packed {
    pixel_req_t req;
    logic       typed;
    wr_result_t res;
  } probe_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Our own copy of the register file, updated after every completed write.
  logic [1:0]  fmt_m;
  logic [12:0] width_m;
  logic [12:0] height_m;
  logic [13:0] stride_m;
  logic [5:0]  offx_m;
  logic [5:0]  offy_m;

  // Writes the block still owes us, oldest first.
  wr_result_t pending_writes[$];

  int err_count = 0;
  int calm_in = 0;
  int calm_out = 0;

  framebuffer_pixel_compositor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs; a correct run needs well under a tenth of this.
  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

  // Prints one line per mismatch and counts.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    err_count++;
  endtask

  // Draws a random idle gap. Now and then a side enters a calm
  // stretch of thirty words with no idling at all, so back-to-back traffic is seen too.
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = 30;
    end
    return $urandom_range(0, 4);
  endfunction

  // Packs three channels in the byte order of the current pixel format.
  function automatic logic [31:0] pack_color(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    return (fmt_m == FMT_RED_LOW) ? {8'h00, b, g, r} : {8'h00, r, g, b};
  endfunction

  // Source-over for one premultiplied channel, clamped at full scale.
  function automatic logic [7:0] blend_chan(input int unsigned src, input int unsigned dst,
                                            input int unsigned inv);
    int unsigned v;
    v = src + (dst * inv) / 255;
    return (v > 255) ? 8'hff : v[7:0];
  endfunction

  // Works out the write that one request must produce under the current registers.
  function automatic wr_result_t predict_write(input pixel_req_t q);
    int unsigned xs;
    int unsigned ys;
    int unsigned level;
    int unsigned inv;
    logic [7:0]  rr;
    logic [7:0]  gg;
    logic [7:0]  bb;
    logic        hit;
    logic [31:0] word;
    wr_result_t  res;
    xs = 32'(q.x) + 32'(offx_m);
    ys = 32'(q.y) + 32'(offy_m);
    hit = 1'b0;
    word = '0;
    case (q.kind)
      KIND_GLYPH: begin
        // Coverage is dimmed to at most the maximum level and written as grey when it survives.
        level = (32'(q.r) * 32'(MAX_LEVEL)) / 255;
        if (level != 0) begin
          hit = 1'b1;
          word = pack_color(level[7:0], level[7:0], level[7:0]);
        end
      end
      KIND_LOGO: begin
        // Fully transparent logo pixels leave the framebuffer untouched;
        // fully opaque ones replace it.
        if (q.a != 8'h00) begin
          hit = 1'b1;
          rr = q.r;
          gg = q.g;
          bb = q.b;
          if (q.a != 8'hff) begin
            inv = 255 - 32'(q.a);
            rr = blend_chan(32'(q.r), (fmt_m == FMT_RED_LOW) ? 32'(q.under[7:0])
                                                             : 32'(q.under[23:16]), inv);
            gg = blend_chan(32'(q.g), 32'(q.under[15:8]), inv);
            bb = blend_chan(32'(q.b), (fmt_m == FMT_RED_LOW) ? 32'(q.under[23:16])
                                                             : 32'(q.under[7:0]), inv);
          end
          word = pack_color(rr, gg, bb);
        end
      end
      KIND_FILL: begin
        hit = 1'b1;
        word = pack_color(q.r, q.g, q.b);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    if (xs >= 32'(width_m) || ys >= 32'(height_m)) begin
      hit = 1'b0;
    end
    res.we = hit;
    res.addr = hit ? 25'(ys * 32'(stride_m) + xs) : 25'd0;
    res.pix = hit ? word : 32'd0;
    return res;
  endfunction

  // Builds a random request. Most coordinates land on the visible screen so
  // that writes actually happen; a quarter range over the whole field.
  function automatic pixel_req_t random_pixel();
    pixel_req_t q;
    int k;
    int lim;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      q.kind = KIND_GLYPH;
    end else if (k < 6) begin
      q.kind = KIND_LOGO;
    end else if (k < 9) begin
      q.kind = KIND_FILL;
    end else begin
      q.kind = KIND_SPARE;
    end
    lim = int'(width_m) - 1 - int'(offx_m);
    if ($urandom_range(0, 3) != 0 && lim >= 0) begin
      q.x = 12'($urandom_range(0, (lim > 4095) ? 4095 : lim));
    end else begin
      q.x = 12'($urandom_range(0, 4095));
    end
    lim = int'(height_m) - 1 - int'(offy_m);
    if ($urandom_range(0, 3) != 0 && lim >= 0) begin
      q.y = 12'($urandom_range(0, (lim > 4095) ? 4095 : lim));
    end else begin
      q.y = 12'($urandom_range(0, 4095));
    end
    q.r = 8'($urandom);
    q.g = 8'($urandom);
    q.b = 8'($urandom);
    k = $urandom_range(0, 7);
    q.a = (k == 0) ? 8'h00 : (k == 1) ? 8'hff : 8'($urandom);
    q.under = $urandom;
    return q;
  endfunction

  // Offers one request word after a random gap and waits for it to be taken.
  // The expectation is queued at the edge of acceptance, under the registers
  // in force at that moment.
  task automatic push_pixel(input pixel_req_t req, input logic typed,
                            input wr_result_t typed_res);
    int gap;
    gap = pick_gap(calm_in);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {req.under, req.a, req.b, req.g, req.r, req.y, req.x};
    in_tuser <= req.kind;
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_writes.push_back(typed ? typed_res : predict_write(req));
  endtask

  // Stops sending and lets every owed result drain, plus a settling margin.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Bus write: setup cycle, then access until pready. The bus goes idle
  // afterwards so back-to-back transfers never retoggle psel in one step.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PIXEL_FORMAT:  fmt_m = val[1:0];
      REG_SCREEN_WIDTH:  width_m = val[12:0];
      REG_SCREEN_HEIGHT: height_m = val[12:0];
      REG_ROW_STRIDE:    stride_m = val[13:0];
      REG_OFFSET_X:      offx_m = val[5:0];
      REG_OFFSET_Y:      offy_m = val[5:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Bus read, compared against our copy of the register.
  task automatic cfg_read(input logic [2:0] idx);
    logic [31:0] want;
    case (idx)
      REG_PIXEL_FORMAT:  want = 32'(fmt_m);
      REG_SCREEN_WIDTH:  want = 32'(width_m);
      REG_SCREEN_HEIGHT: want = 32'(height_m);
      REG_ROW_STRIDE:    want = 32'(stride_m);
      REG_OFFSET_X:      want = 32'(offx_m);
      REG_OFFSET_Y:      want = 32'(offy_m);
      default:           want = '0;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      report_mismatch("register readback", 64'(prdata), 64'(want));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Loads a complete screen setting and reads every register back.
  task automatic program_screen(input logic [1:0] fmt, input logic [12:0] w,
                                input logic [12:0] h, input logic [13:0] stride,
                                input logic [5:0] ox, input logic [5:0] oy);
    cfg_write(REG_PIXEL_FORMAT, 32'(fmt));
    cfg_write(REG_SCREEN_WIDTH, 32'(w));
    cfg_write(REG_SCREEN_HEIGHT, 32'(h));
    cfg_write(REG_ROW_STRIDE, 32'(stride));
    cfg_write(REG_OFFSET_X, 32'(ox));
    cfg_write(REG_OFFSET_Y, 32'(oy));
    for (int i = REG_PIXEL_FORMAT; i <= REG_OFFSET_Y; i++) begin
      cfg_read(3'(i));
    end
  endtask

  // Result side: the receiver idles at random before each word, then takes
  // whatever arrives and compares it, field by field, with the oldest pending write.
  initial begin
    int gap;
    wr_result_t want;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = pick_gap(calm_out);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (pending_writes.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, 64'd0);
      end else begin
        want = pending_writes.pop_front();
        if (out_tuser !== want.we) begin
          report_mismatch("write_enable", 64'(out_tuser), 64'(want.we));
        end
        if (out_tdata[24:0] !== want.addr) begin
          report_mismatch("write_address", 64'(out_tdata[24:0]), 64'(want.addr));
        end
        if (out_tdata[56:25] !== want.pix) begin
          report_mismatch("pixel_value", 64'(out_tdata[56:25]), 64'(want.pix));
        end
        if (out_tdata[63:57] !== 7'd0) begin
          report_mismatch("tdata zero fill", 64'(out_tdata[63:57]), 64'd0);
        end
      end
    end
  end

  // Directed table, run under the reset register values (format 1, 1024 x 768,
  // stride 1024, no offset). Rows with typed = 1 carry their write directly.
  probe_row_t probe_rows [20] = '{
    // Full coverage dims to the peak grey level.
    '{'{KIND_GLYPH, 12'd0, 12'd0, 8'hff, 8'h00, 8'h00, 8'h00, 32'h0},
      1'b1, '{1'b1, 25'd0, 32'h00c0c0c0}},
    // Coverage of one dims to zero and is not written.
    '{'{KIND_GLYPH, 12'd10, 12'd10, 8'h01, 8'hff, 8'hff, 8'hff, 32'hffffffff},
      1'b1, '{1'b0, 25'd0, 32'h0}},
    '{'{KIND_GLYPH, 12'd10, 12'd10, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0},
      1'b1, '{1'b0, 25'd0, 32'h0}},
    // Smallest coverage that still writes.
    '{'{KIND_GLYPH, 12'd5, 12'd3, 8'h02, 8'h00, 8'h00, 8'h00, 32'h0},
      1'b0, '{1'b0, 25'd0, 32'h0}},
    '{'{KIND_GLYPH, 12'd1023, 12'd767, 8'h80, 8'h11, 8'h22, 8'h33, 32'hffffffff},
      1'b0, '{1'b0, 25'd0, 32'h0}},
    // Fill at the last visible pixel.
    '{'{KIND_FILL, 12'd1023, 12'd767, 8'h12, 8'h34, 8'h56, 8'h00, 32'h0},
      1'b1, '{1'b1, 25'h00bffff, 32'h00123456}},
    // One past the right edge, one past the bottom edge, and the far corner.
    '{'{KIND_FILL, 12'd1024, 12'd0, 8'h12, 8'h34, 8'h56, 8'h00, 32'h0},
      1'b1, '{1'b0, 25'd0, 32'h0}},
    '{'{KIND_FILL, 12'd0, 12'd768, 8'h12, 8'h34, 8'h56, 8'h00, 32'h0},
      1'b1, '{1'b0, 25'd0, 32'h0}},
    '{'{KIND_FILL, 12'd4095, 12'd4095, 8'hff, 8'hff, 8'hff, 8'hff, 32'hffffffff},
      1'b1, '{1'b0, 25'd0, 32'h0}},
    // Black fill still writes.
    '{'{KIND_FILL, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'hffffffff},
      1'b1, '{1'b1, 25'd0, 32'h0}},
    '{'{KIND_FILL, 12'd4, 12'd0, 8'hff, 8'hff, 8'hff, 8'h00, 32'h0},
      1'b1, '{1'b1, 25'd4, 32'h00ffffff}},
    // Transparent logo pixel is skipped.
    '{'{KIND_LOGO, 12'd1, 12'd1, 8'hff, 8'hff, 8'hff, 8'h00, 32'h0},
      1'b1, '{1'b0, 25'd0, 32'h0}},
    // Opaque logo pixel replaces the framebuffer word.
    '{'{KIND_LOGO, 12'd2, 12'd1, 8'hab, 8'hcd, 8'hef, 8'hff, 32'h12345678},
      1'b1, '{1'b1, 25'd1026, 32'h00abcdef}},
    '{'{KIND_LOGO, 12'd7, 12'd9, 8'h40, 8'h80, 8'hc0, 8'h80, 32'hff102030},
      1'b0, '{1'b0, 25'd0, 32'h0}},
    // Nearly transparent bright source over white: every channel saturates.
    '{'{KIND_LOGO, 12'd100, 12'd200, 8'hff, 8'hff, 8'hff, 8'h01, 32'hffffffff},
      1'b0, '{1'b0, 25'd0, 32'h0}},
    '{'{KIND_LOGO, 12'd3, 12'd3, 8'h00, 8'h00, 8'h00, 8'hfe, 32'h00ffffff},
      1'b0, '{1'b0, 25'd0, 32'h0}},
    '{'{KIND_LOGO, 12'd1023, 12'd0, 8'h00, 8'h00, 8'h00, 8'h01, 32'h0},
      1'b0, '{1'b0, 25'd0, 32'h0}},
    // The spare kind never writes, whatever its fields say.
    '{'{KIND_SPARE, 12'd0, 12'd0, 8'h12, 8'h34, 8'h56, 8'hff, 32'h0},
      1'b1, '{1'b0, 25'd0, 32'h0}},
    '{'{KIND_SPARE, 12'd4095, 12'd4095, 8'hff, 8'hff, 8'hff, 8'hff, 32'hffffffff},
      1'b1, '{1'b0, 25'd0, 32'h0}},
    // Opaque logo just off screen.
    '{'{KIND_LOGO, 12'd1024, 12'd767, 8'hff, 8'hff, 8'hff, 8'hff, 32'h0},
      1'b1, '{1'b0, 25'd0, 32'h0}}
  };

  // Main sequence: reset, check the register defaults, walk the directed
  // table, then run random traffic under a series of screen settings. Every
  // setting change happens only after all owed results have come back.
  initial begin
    fmt_m = 2'd1;
    width_m = 13'd1024;
    height_m = 13'd768;
    stride_m = 14'd1024;
    offx_m = 6'd0;
    offy_m = 6'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = REG_PIXEL_FORMAT; i <= REG_OFFSET_Y; i++) begin
      cfg_read(3'(i));
    end

    foreach (probe_rows[i]) begin
      push_pixel(probe_rows[i].req, probe_rows[i].typed, probe_rows[i].res);
    end
    settle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        // Largest nominal screen and offsets, red in the low byte.
        0: program_screen(FMT_RED_LOW, 13'd4096, 13'd4096, 14'd8192, 6'd32, 6'd32);
        // A single visible pixel, spare format code.
        1: program_screen(2'd3, 13'd1, 13'd1, 14'd1, 6'd0, 6'd0);
        // Widest stride and offsets the registers hold: addresses wrap at 25 bits.
        2: program_screen(2'd2, 13'd4096, 13'd4096, 14'd16383, 6'd63, 6'd63);
        // Zero-sized screen blocks every write.
        3: program_screen(2'd1, 13'd0, 13'd0, 14'd5, 6'd7, 6'd1);
        4: program_screen(FMT_RED_LOW, 13'd800, 13'd600, 14'd1000, 6'd17, 6'd9);
        default: program_screen(2'($urandom_range(0, 3)), 13'($urandom_range(1, 4096)),
                                13'($urandom_range(1, 4096)), 14'($urandom_range(1, 8192)),
                                6'($urandom_range(0, 32)), 6'($urandom_range(0, 32)));
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Once mid-phase, hold the input until the pipeline has fully emptied.
        if (p == 4 && n == PHASE_WORDS / 2) begin
          settle();
        end
        push_pixel(random_pixel(), 1'b0, '0);
      end
      settle();
    end

    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
design/fbpc_pkg.sv
design/fbpc_front.sv
design/fbpc_queue.sv
design/fbpc_back.sv
design/framebuffer_pixel_compositor.sv
tb/tb.sv
